// ===== sv/assert_macros.svh =====
// Assertion helpers included by buddy_page_allocator.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BPA_ASSERT_TOP(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`else
`define BPA_ASSERT(lbl, clk, rst_n, prop)
`define BPA_ASSERT_TOP(lbl, prop)
`endif
`endif

// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
package bpa_pkg;
    localparam int PAGE_N     = 32768;
    localparam int PAGE_W     = $clog2(PAGE_N);
    localparam int TOP_RANK   = 16;
    localparam int RANK_W     = 5;
    localparam int RIDX_W     = $clog2(TOP_RANK);
    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int CNT_W      = 16;

    localparam logic [2:0] K_INIT   = 3'd0;
    localparam logic [2:0] K_ALLOC  = 3'd1;
    localparam logic [2:0] K_FREE   = 3'd2;
    localparam logic [2:0] K_QRANK  = 3'd3;
    localparam logic [2:0] K_QCOUNT = 3'd4;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVAL   = 2'd1,
        STS_NOSPACE = 2'd2
    } t_status;

    typedef struct packed {
        logic              nul;
        logic [PAGE_W-1:0] idx;
    } t_link;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              alloc;
        logic              fhead;
    } t_meta;
endpackage

// ===== sv/bpa_ram.sv =====
`timescale 1ns / 1ps
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Content
// s_axis    in   i_s_tvalid/o_s_tready     tuser kind, tdata rank + address
// m_axis    out  o_m_tvalid/i_m_tready     tuser status, tdata block_address + value
// cfg       in   i_cfg_valid/o_cfg_ready   index 0 base_address, 1 page_count
//
// One word at a time; the link and page-state memories have one port each, so list
// edits go one after another. Count query and bad arguments go straight to the
// result; rank query reads the page state, alloc scans ranks upward and then splits,
// free merges with free buddies. Init and reset run a clearing pass over all 32768
// pages of the page memories, then init carves the pool into blocks from the top rank
// down; s_axis is low meanwhile. A finished result stalls while the output register
// is full and not taken; once it moves there the block is ready again the cycle after.
`include "assert_macros.svh"
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [2:0]  i_s_tuser,   // [2:0] kind
    input  logic [55:0] i_s_tdata,   // [4:0] rank, [52:5] address, [55:53] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic [63:0] o_m_tdata,   // [47:0] block_address, [63:48] value
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    typedef enum logic [14:0] {
        ST_CLEAR     = 15'h0001,
        ST_IDLE      = 15'h0002,
        ST_DECODE    = 15'h0004,
        ST_SCAN      = 15'h0008,
        ST_UL_RD     = 15'h0010,
        ST_UL_WR     = 15'h0020,
        ST_SPLIT     = 15'h0040,
        ST_PUSH_A    = 15'h0080,
        ST_PUSH_B    = 15'h0100,
        ST_FREE_CHK  = 15'h0200,
        ST_MERGE     = 15'h0400,
        ST_MERGE_CHK = 15'h0800,
        ST_QRANK     = 15'h1000,
        ST_CARVE     = 15'h2000,
        ST_DONE      = 15'h4000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]        r_kind, n_kind;
    logic [RANK_W-1:0] r_rq, n_rq, r_r, n_r;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [PAGE_W-1:0] r_pg, n_pg, r_ul, n_ul, r_tl, n_tl, r_clr, n_clr;
    logic [CNT_W-1:0]  r_cur, n_cur;
    logic              r_init, n_init;
    t_status           r_res_st, n_res_st;
    logic [ADDR_W-1:0] r_res_blk, n_res_blk;
    logic [CNT_W-1:0]  r_res_val, n_res_val;
    logic              r_ovalid, n_ovalid;
    t_status           r_ost, n_ost;
    logic [ADDR_W-1:0] r_oblk, n_oblk;
    logic [CNT_W-1:0]  r_oval, n_oval;
    logic [ADDR_W-1:0] r_base;
    logic [CNT_W-1:0]  r_pcnt;
    logic [PAGE_W-1:0] r_head [TOP_RANK];
    logic [PAGE_W-1:0] n_head [TOP_RANK];
    logic [PAGE_W-1:0] r_tail [TOP_RANK];
    logic [PAGE_W-1:0] n_tail [TOP_RANK];
    logic [CNT_W-1:0]  r_cnt  [TOP_RANK];
    logic [CNT_W-1:0]  n_cnt  [TOP_RANK];

    logic              nx_we, pv_we, mt_we;
    logic [PAGE_W-1:0] nx_addr, pv_addr, mt_addr;
    t_link             nx_wd, pv_wd, nx_rd, pv_rd;
    t_meta             mt_wd, mt_rd;

    logic [CNT_W-1:0]  pool_n;
    logic [RIDX_W-1:0] rk, rqk;
    logic [ADDR_W-1:0] off;
    logic              pg_ok, rank_ok;
    logic [PAGE_W-1:0] pg_calc, b_split, b_merge, pg_min;
    logic [CNT_W-1:0]  sz;
    logic [CNT_W:0]    cur_end;
    logic [RANK_W-1:0] rn;

    bpa_ram #(.WIDTH($bits(t_link)), .DEPTH(PAGE_N)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_addr(nx_addr), .i_wdata(nx_wd), .o_rdata(nx_rd)
    );
    bpa_ram #(.WIDTH($bits(t_link)), .DEPTH(PAGE_N)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_addr(pv_addr), .i_wdata(pv_wd), .o_rdata(pv_rd)
    );
    bpa_ram #(.WIDTH($bits(t_meta)), .DEPTH(PAGE_N)) u_meta (
        .i_clk(i_clk), .i_we(mt_we), .i_addr(mt_addr), .i_wdata(mt_wd), .o_rdata(mt_rd)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tuser   = r_ost;
    assign o_m_tdata   = {r_oval, r_oblk};

    always_comb begin
        pool_n  = (r_pcnt > CNT_W'(PAGE_N)) ? CNT_W'(PAGE_N) : r_pcnt;
        rk      = RIDX_W'(r_r - RANK_W'(1));
        rqk     = RIDX_W'(r_rq - RANK_W'(1));
        rank_ok = (r_rq >= RANK_W'(1)) && (r_rq <= RANK_W'(TOP_RANK));
        off     = r_addr - r_base;
        pg_ok   = (r_addr >= r_base) && (off[PAGE_SHIFT-1:0] == '0)
                  && (off[ADDR_W-1:PAGE_SHIFT] < (ADDR_W-PAGE_SHIFT)'(pool_n));
        pg_calc = off[PAGE_SHIFT +: PAGE_W];
        sz      = CNT_W'(1) << (r_r - RANK_W'(1));
        cur_end = {1'b0, r_cur} + {1'b0, sz};
        rn      = r_r - RANK_W'(1);
        b_split = r_pg + (PAGE_W'(1) << (rn - RANK_W'(1)));
        b_merge = r_pg ^ (PAGE_W'(1) << (r_r - RANK_W'(1)));
        pg_min  = (r_ul < r_pg) ? r_ul : r_pg;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_kind    = r_kind;
        n_rq      = r_rq;
        n_r       = r_r;
        n_addr    = r_addr;
        n_pg      = r_pg;
        n_ul      = r_ul;
        n_tl      = r_tl;
        n_clr     = r_clr;
        n_cur     = r_cur;
        n_init    = r_init;
        n_res_st  = r_res_st;
        n_res_blk = r_res_blk;
        n_res_val = r_res_val;
        n_ovalid  = r_ovalid & ~i_m_tready;
        n_ost     = r_ost;
        n_oblk    = r_oblk;
        n_oval    = r_oval;
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        nx_we     = 1'b0;
        pv_we     = 1'b0;
        mt_we     = 1'b0;
        nx_addr   = r_ul;
        pv_addr   = r_ul;
        mt_addr   = r_ul;
        nx_wd     = '{nul: 1'b1, idx: '0};
        pv_wd     = '{nul: 1'b1, idx: '0};
        mt_wd     = '0;

        unique case (r_state)
            ST_CLEAR: begin
                nx_we   = 1'b1;
                pv_we   = 1'b1;
                mt_we   = 1'b1;
                nx_addr = r_clr;
                pv_addr = r_clr;
                mt_addr = r_clr;
                n_clr   = r_clr + PAGE_W'(1);
                if (&r_clr) begin
                    n_init = 1'b0;
                    if (r_init) begin
                        n_state = ST_CARVE;
                        n_r     = RANK_W'(TOP_RANK);
                        n_cur   = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind  = i_s_tuser;
                    n_rq    = i_s_tdata[4:0];
                    n_addr  = i_s_tdata[52:5];
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_res_st  = STS_INVAL;
                n_res_blk = '0;
                n_res_val = '0;
                n_pg      = pg_calc;
                n_state   = ST_DONE;
                mt_addr   = pg_calc;
                unique case (r_kind)
                    K_INIT: begin
                        n_res_st = STS_OK;
                        for (int i = 0; i < TOP_RANK; i++) begin
                            n_cnt[i] = '0;
                        end
                        n_clr   = '0;
                        n_init  = 1'b1;
                        n_state = ST_CLEAR;
                    end
                    K_ALLOC: begin
                        if (rank_ok) begin
                            n_r     = r_rq;
                            n_state = ST_SCAN;
                        end
                    end
                    K_FREE: begin
                        if (pg_ok) begin
                            n_state = ST_FREE_CHK;
                        end
                    end
                    K_QRANK: begin
                        if (pg_ok) begin
                            n_state = ST_QRANK;
                        end
                    end
                    K_QCOUNT: begin
                        if (rank_ok) begin
                            n_res_st  = STS_OK;
                            n_res_val = r_cnt[rqk];
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (r_cnt[rk] != '0) begin
                    n_pg    = r_head[rk];
                    n_ul    = r_head[rk];
                    n_state = ST_UL_RD;
                end else if (r_r == RANK_W'(TOP_RANK)) begin
                    n_res_st = STS_NOSPACE;
                    n_state  = ST_DONE;
                end else begin
                    n_r = r_r + RANK_W'(1);
                end
            end
            ST_UL_RD: begin
                n_state = ST_UL_WR;
            end
            ST_UL_WR: begin
                // splice the neighbors around the page, or move head / tail
                if (!pv_rd.nul) begin
                    nx_we   = 1'b1;
                    nx_addr = pv_rd.idx;
                    nx_wd   = nx_rd;
                end else begin
                    n_head[rk] = nx_rd.idx;
                end
                if (!nx_rd.nul) begin
                    pv_we   = 1'b1;
                    pv_addr = nx_rd.idx;
                    pv_wd   = pv_rd;
                end else begin
                    n_tail[rk] = pv_rd.idx;
                end
                n_cnt[rk] = r_cnt[rk] - CNT_W'(1);
                if (r_kind == K_FREE) begin
                    n_pg    = pg_min;
                    n_r     = r_r + RANK_W'(1);
                    mt_we   = 1'b1;
                    mt_addr = pg_min;
                    mt_wd   = '{rank: r_r + RANK_W'(1), alloc: 1'b0, fhead: 1'b0};
                    n_state = ST_MERGE;
                end else begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (r_r > r_rq) begin
                    n_r     = rn;
                    n_ul    = b_split;
                    n_ret   = ST_SPLIT;
                    n_state = ST_PUSH_A;
                end else begin
                    mt_we     = 1'b1;
                    mt_addr   = r_pg;
                    mt_wd     = '{rank: r_rq, alloc: 1'b1, fhead: 1'b0};
                    n_res_st  = STS_OK;
                    n_res_blk = r_base + ADDR_W'({r_pg, {PAGE_SHIFT{1'b0}}});
                    n_state   = ST_DONE;
                end
            end
            ST_PUSH_A: begin
                mt_we = 1'b1;
                mt_wd = '{rank: r_r, alloc: 1'b0, fhead: 1'b1};
                nx_we = 1'b1;
                pv_we = 1'b1;
                if (r_cnt[rk] == '0) begin
                    n_head[rk] = r_ul;
                    n_state    = r_ret;
                end else begin
                    pv_wd   = '{nul: 1'b0, idx: r_tail[rk]};
                    n_tl    = r_tail[rk];
                    n_state = ST_PUSH_B;
                end
                n_tail[rk] = r_ul;
                n_cnt[rk]  = r_cnt[rk] + CNT_W'(1);
            end
            ST_PUSH_B: begin
                nx_we   = 1'b1;
                nx_addr = r_tl;
                nx_wd   = '{nul: 1'b0, idx: r_ul};
                n_state = r_ret;
            end
            ST_FREE_CHK: begin
                if (mt_rd.alloc) begin
                    mt_we    = 1'b1;
                    mt_addr  = r_pg;
                    mt_wd    = '{rank: mt_rd.rank, alloc: 1'b0, fhead: mt_rd.fhead};
                    n_res_st = STS_OK;
                    n_r      = mt_rd.rank;
                    if (mt_rd.rank >= RANK_W'(1) && mt_rd.rank <= RANK_W'(TOP_RANK)) begin
                        n_state = ST_MERGE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MERGE: begin
                if (r_r == RANK_W'(TOP_RANK) || CNT_W'(b_merge) >= pool_n) begin
                    n_ul    = r_pg;
                    n_ret   = ST_DONE;
                    n_state = ST_PUSH_A;
                end else begin
                    mt_addr = b_merge;
                    n_ul    = b_merge;
                    n_state = ST_MERGE_CHK;
                end
            end
            ST_MERGE_CHK: begin
                if (mt_rd.fhead && !mt_rd.alloc && mt_rd.rank == r_r) begin
                    n_state = ST_UL_RD;
                end else begin
                    n_ul    = r_pg;
                    n_ret   = ST_DONE;
                    n_state = ST_PUSH_A;
                end
            end
            ST_QRANK: begin
                n_res_st  = STS_OK;
                n_res_val = CNT_W'(mt_rd.rank);
                n_state   = ST_DONE;
            end
            ST_CARVE: begin
                if (cur_end <= {1'b0, pool_n}) begin
                    n_ul    = r_cur[PAGE_W-1:0];
                    n_cur   = cur_end[CNT_W-1:0];
                    n_ret   = ST_CARVE;
                    n_state = ST_PUSH_A;
                end else if (r_r == RANK_W'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_r = rn;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_oblk   = r_res_blk;
                    n_oval   = r_res_val;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ret    <= ST_DONE;
            r_clr    <= '0;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
            r_base   <= '0;
            r_pcnt   <= CNT_W'(1);
            for (int i = 0; i < TOP_RANK; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_clr    <= n_clr;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_pcnt <= i_cfg_data[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_rq      <= n_rq;
        r_r       <= n_r;
        r_addr    <= n_addr;
        r_pg      <= n_pg;
        r_ul      <= n_ul;
        r_tl      <= n_tl;
        r_cur     <= n_cur;
        r_res_st  <= n_res_st;
        r_res_blk <= n_res_blk;
        r_res_val <= n_res_val;
        r_ost     <= n_ost;
        r_oblk    <= n_oblk;
        r_oval    <= n_oval;
        r_head    <= n_head;
        r_tail    <= n_tail;
    end

    `BPA_ASSERT_TOP(a_busy_after_accept, (i_s_tvalid && o_s_tready) |=> !o_s_tready)
    `BPA_ASSERT_TOP(a_result_held, (r_ovalid && !i_m_tready) |=> r_ovalid)
    `BPA_ASSERT(a_unlink_nonempty, i_clk, i_rst_n, (r_state == ST_UL_WR) |-> (r_cnt[rk] != '0))
    `BPA_ASSERT(a_push_order, i_clk, i_rst_n, (r_state == ST_PUSH_B) |-> ($past(r_state) == ST_PUSH_A))
endmodule

// ===== tb/sv/buddy_page_allocator_test.sv =====
`timescale 1ns / 1ps
module buddy_page_allocator_test;
    import bpa_pkg::*;

    localparam int      DRAIN_CYCLES = 200;
    localparam longint  CYCLE_LIMIT  = 4000000;
    localparam logic [2:0] K_UNUSED_LO = 3'd5;
    localparam logic [2:0] K_UNUSED_HI = 3'd7;

    typedef struct {
        t_status     status;
        logic [47:0] blk;
        logic [15:0] value;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [2:0]  i_s_tuser;
    logic [55:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [1:0]  o_m_tuser;
    logic [63:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [47:0] i_cfg_data;

    buddy_page_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // allocator mirror
    logic [47:0] pool_base;
    logic [15:0] pool_pages_reg;
    logic [15:0] link_nxt [PAGE_N];
    logic [15:0] link_prv [PAGE_N];
    bit          nxt_nul  [PAGE_N];
    bit          prv_nul  [PAGE_N];
    logic [4:0]  blk_rank [PAGE_N];
    bit          blk_used [PAGE_N];
    bit          blk_head [PAGE_N];
    int          free_head  [TOP_RANK+1];
    int          free_tail  [TOP_RANK+1];
    int          free_count [TOP_RANK+1];

    t_reply      pending_replies [$];
    logic [47:0] live_blocks [$];
    int          err_count;
    longint      cycle_count;
    int          burst_left;
    bit          hold_req;

    function automatic int pool_size();
        return (pool_pages_reg > PAGE_N) ? PAGE_N : int'(pool_pages_reg);
    endfunction

    function automatic void wipe_pool();
        for (int p = 0; p < PAGE_N; p++) begin
            link_nxt[p] = '0;
            link_prv[p] = '0;
            nxt_nul[p]  = 1'b1;
            prv_nul[p]  = 1'b1;
            blk_rank[p] = '0;
            blk_used[p] = 1'b0;
            blk_head[p] = 1'b0;
        end
        for (int r = 0; r <= TOP_RANK; r++) begin
            free_head[r]  = 0;
            free_tail[r]  = 0;
            free_count[r] = 0;
        end
    endfunction

    function automatic void list_append(int r, int pg);
        int t;
        nxt_nul[pg]  = 1'b1;
        link_nxt[pg] = '0;
        if (free_count[r] == 0) begin
            prv_nul[pg]  = 1'b1;
            link_prv[pg] = '0;
            free_head[r] = pg;
        end else begin
            t = free_tail[r];
            prv_nul[pg]  = 1'b0;
            link_prv[pg] = 16'(t);
            link_nxt[t]  = 16'(pg);
            nxt_nul[t]   = 1'b0;
        end
        free_tail[r] = pg;
        free_count[r]++;
        blk_head[pg] = 1'b1;
    endfunction

    function automatic void list_unlink(int r, int pg);
        int p;
        int n;
        bit pn;
        bit nn;
        p  = link_prv[pg];
        n  = link_nxt[pg];
        pn = prv_nul[pg];
        nn = nxt_nul[pg];
        if (!pn) begin
            link_nxt[p] = 16'(n);
            nxt_nul[p]  = nn;
        end else begin
            free_head[r] = n;
        end
        if (!nn) begin
            link_prv[n] = 16'(p);
            prv_nul[n]  = pn;
        end else begin
            free_tail[r] = p;
        end
        nxt_nul[pg] = 1'b1;
        prv_nul[pg] = 1'b1;
        if (free_count[r] > 0) free_count[r]--;
        blk_head[pg] = 1'b0;
    endfunction

    function automatic bit page_index(logic [47:0] addr, output int pg);
        logic [47:0] off;
        pg = 0;
        if (addr < pool_base) return 1'b0;
        off = addr - pool_base;
        if (off[11:0] != '0) return 1'b0;
        if (off[47:12] >= 36'(pool_size())) return 1'b0;
        pg = int'(off[47:12]);
        return 1'b1;
    endfunction

    function automatic logic [47:0] page_addr(int pg);
        return pool_base + (48'(pg) << PAGE_SHIFT);
    endfunction

    function automatic t_reply apply_request(logic [2:0] kind, logic [4:0] rq,
                                             logic [47:0] addr);
        t_reply res;
        int     n;
        int     pg;
        int     cur;
        int     r;
        int     b;
        bit     rank_ok;
        res.status = STS_INVAL;
        res.blk    = '0;
        res.value  = '0;
        n       = pool_size();
        rank_ok = (rq >= 1) && (rq <= TOP_RANK);
        case (kind)
            K_INIT: begin
                wipe_pool();
                cur = 0;
                for (r = TOP_RANK; r >= 1; r--) begin
                    while (cur + (1 << (r - 1)) <= n) begin
                        blk_rank[cur] = 5'(r);
                        list_append(r, cur);
                        cur += 1 << (r - 1);
                    end
                end
                res.status = STS_OK;
            end
            K_ALLOC: begin
                if (rank_ok) begin
                    r = rq;
                    while (r <= TOP_RANK && free_count[r] == 0) r++;
                    if (r > TOP_RANK) begin
                        res.status = STS_NOSPACE;
                    end else begin
                        pg = free_head[r];
                        list_unlink(r, pg);
                        while (r > rq) begin
                            r--;
                            b = pg + (1 << (r - 1));
                            blk_rank[b] = 5'(r);
                            list_append(r, b);
                        end
                        blk_rank[pg] = rq;
                        blk_used[pg] = 1'b1;
                        res.blk    = page_addr(pg);
                        res.status = STS_OK;
                    end
                end
            end
            K_FREE: begin
                if (page_index(addr, pg) && blk_used[pg]) begin
                    r = blk_rank[pg];
                    blk_used[pg] = 1'b0;
                    if (r >= 1 && r <= TOP_RANK) begin
                        // climb while the buddy is a free head of equal rank
                        while (r < TOP_RANK) begin
                            b = pg ^ (1 << (r - 1));
                            if (b >= n || !blk_head[b] || blk_used[b] || blk_rank[b] != r)
                                break;
                            list_unlink(r, b);
                            if (b < pg) pg = b;
                            r++;
                            blk_rank[pg] = 5'(r);
                        end
                        list_append(r, pg);
                    end
                    res.status = STS_OK;
                end
            end
            K_QRANK: begin
                if (page_index(addr, pg)) begin
                    res.value  = 16'(blk_rank[pg]);
                    res.status = STS_OK;
                end
            end
            K_QCOUNT: begin
                if (rank_ok) begin
                    res.value  = 16'(free_count[rq]);
                    res.status = STS_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic send_word(logic [2:0] kind, logic [4:0] rq, logic [47:0] addr);
        t_reply res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {3'b000, addr, rq};
        do @(posedge i_clk); while (!o_s_tready);
        res = apply_request(kind, rq, addr);
        pending_replies.push_back(res);
        if (kind == K_ALLOC && res.status == STS_OK) live_blocks.push_back(res.blk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_BASE) pool_base = data;
        else pool_pages_reg = data[15:0];
        @(posedge i_clk);
    endtask

    task automatic set_pool(logic [47:0] base, logic [15:0] pages);
        write_reg(CFG_BASE, base);
        write_reg(CFG_PAGES, 48'(pages));
    endtask

    task automatic free_live(int k);
        logic [47:0] a;
        a = live_blocks[k];
        live_blocks.delete(k);
        send_word(K_FREE, '0, a);
    endtask

    // output side: check each word, stall on its own pattern
    int rx_mode;
    int rx_left;
    int hold_left;
    bit hold_seen;
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_replies.size() == 0) begin
                report("unexpected word", o_m_tdata, '0);
            end else begin
                want = pending_replies.pop_front();
                if (o_m_tuser != want.status) report("status", o_m_tuser, want.status);
                if (o_m_tdata[47:0] != want.blk) report("block_address", o_m_tdata[47:0], want.blk);
                if (o_m_tdata[63:48] != want.value) report("value", o_m_tdata[63:48], want.value);
            end
        end
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = 3000;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0, 1: i_m_tready <= 1'b1;
                2: i_m_tready <= $urandom_range(0, 1);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("buddy_page_allocator: mismatch");
            $finish;
        end
    end

    task automatic test_before_init();
        send_word(K_ALLOC, 5'd1, '0);
        send_word(K_FREE, '0, '0);
        send_word(K_QRANK, '0, '0);
        send_word(K_QCOUNT, 5'd1, '0);
        for (int k = K_UNUSED_LO; k <= K_UNUSED_HI; k++) send_word(3'(k), 5'd1, '0);
        wait_idle();
    endtask

    task automatic test_small_pool();
        logic [47:0] b;
        b = 48'hABCD_EF01_2000;
        set_pool(b, 16'd13);
        live_blocks.delete();
        send_word(K_INIT, '0, '0);
        send_word(K_ALLOC, 5'd1, '0);
        send_word(K_ALLOC, 5'd2, '0);
        send_word(K_ALLOC, 5'd3, '0);
        send_word(K_ALLOC, 5'd16, '0);
        send_word(K_ALLOC, 5'd0, '0);
        send_word(K_ALLOC, 5'd17, '0);
        send_word(K_ALLOC, 5'd31, '0);
        for (int r = 0; r <= 4; r++) send_word(K_QCOUNT, 5'(r), '0);
        send_word(K_QCOUNT, 5'd31, '0);
        send_word(K_QRANK, '0, b + 48'h1000);
        send_word(K_FREE, '0, b + 48'(13 * 4096));
        send_word(K_FREE, '0, b - 48'h1000);
        send_word(K_FREE, '0, b + 48'h1);
        send_word(K_FREE, '0, live_blocks[2] + 48'h1000);  // interior page
        send_word(K_FREE, '0, live_blocks[0]);
        send_word(K_FREE, '0, live_blocks[0]);             // second release
        live_blocks.delete(0);
        while (live_blocks.size() != 0) free_live(0);
        send_word(K_QCOUNT, 5'd4, '0);
        send_word(K_QRANK, '0, b);
        wait_idle();
    endtask

    task automatic test_full_pool();
        set_pool(48'hFFFF_FFFF_F000, 16'd32768);
        live_blocks.delete();
        send_word(K_INIT, '0, '0);
        send_word(K_ALLOC, 5'd16, '0);
        send_word(K_ALLOC, 5'd1, '0);
        send_word(K_QCOUNT, 5'd16, '0);
        send_word(K_QCOUNT, 5'd15, '0);
        send_word(K_QRANK, '0, page_addr(PAGE_N - 1));
        send_word(K_QRANK, '0, page_addr(16384));
        while (live_blocks.size() != 0) free_live(0);
        send_word(K_QCOUNT, 5'd16, '0);
        wait_idle();
        set_pool(48'hFFFF_FFFF_F000, 16'hFFFF);
        send_word(K_QRANK, '0, page_addr(PAGE_N - 1));
        wait_idle();
    endtask

    task automatic test_empty_pool();
        set_pool('0, 16'd0);
        live_blocks.delete();
        send_word(K_INIT, '0, '0);
        send_word(K_ALLOC, 5'd1, '0);
        send_word(K_QRANK, '0, '0);
        wait_idle();
        set_pool('0, 16'd1);
        send_word(K_INIT, '0, '0);
        send_word(K_ALLOC, 5'd1, '0);
        send_word(K_ALLOC, 5'd1, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          sel;
        logic [47:0] b;
        logic [15:0] pages;
        for (int ph = 0; ph < 10; ph++) begin
            b = 48'({$urandom, $urandom});
            if ($urandom_range(0, 1) == 0) b[11:0] = '0;
            if (ph < 8) pages = 16'($urandom_range(1, 512));
            else if (ph == 8) pages = 16'($urandom_range(1, 32768));
            else pages = 16'($urandom_range(32769, 65535));
            set_pool(b, pages);
            live_blocks.delete();
            send_word(K_INIT, '0, '0);
            for (int i = 0; i < 150; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 35) begin
                    if ($urandom_range(0, 9) == 0) send_word(K_ALLOC, 5'($urandom), '0);
                    else send_word(K_ALLOC, 5'($urandom_range(1, 9)), '0);
                end else if (sel < 65 && live_blocks.size() != 0) begin
                    free_live($urandom_range(0, live_blocks.size() - 1));
                end else if (sel < 75) begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(K_FREE, '0, 48'({$urandom, $urandom}));
                    else
                        send_word(K_FREE, '0,
                                  page_addr($urandom_range(0, pool_size() + 2)));
                end else if (sel < 87) begin
                    send_word(K_QRANK, '0, page_addr($urandom_range(0, pool_size())));
                end else if (sel < 97) begin
                    send_word(K_QCOUNT, 5'($urandom_range(0, 31)), '0);
                end else begin
                    send_word(3'($urandom_range(K_UNUSED_LO, K_UNUSED_HI)),
                              5'($urandom), 48'({$urandom, $urandom}));
                end
            end
            // release everything so merges climb back up
            while (live_blocks.size() != 0)
                free_live($urandom_range(0, live_blocks.size() - 1));
            for (int r = 1; r <= TOP_RANK; r++) send_word(K_QCOUNT, 5'(r), '0);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_pool(48'h0000_0010_0000, 16'd64);
        live_blocks.delete();
        send_word(K_INIT, '0, '0);
        wait_idle();
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 0) send_word(K_ALLOC, 5'($urandom_range(1, 3)), '0);
            else send_word(K_QCOUNT, 5'($urandom_range(1, 7)), '0);
        end
        while (live_blocks.size() != 0) free_live(0);
        wait_idle();
    endtask

    initial begin
        err_count      = 0;
        cycle_count    = 0;
        burst_left     = 0;
        rx_left        = 0;
        rx_mode        = 0;
        hold_left      = 0;
        hold_seen      = 1'b0;
        hold_req       = 1'b0;
        pool_base      = '0;
        pool_pages_reg = 16'd1;
        wipe_pool();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tuser   = '0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_init();
        test_small_pool();
        test_full_pool();
        test_empty_pool();
        test_backpressure();
        test_random_traffic();
        if (err_count == 0) begin
            $display("buddy_page_allocator: match");
        end else begin
            $display("buddy_page_allocator: mismatch");
        end
        $finish;
    end
endmodule
